// File: hdl/sma_pkg.sv
`default_nettype none
package sma_pkg;

  localparam int VALUE_BINS = 256;
  localparam int MAX_WINDOW = 1024;

  localparam int VAL_W   = 8;
  localparam int BIN_W   = $clog2(VALUE_BINS);
  localparam int PTR_W   = $clog2(MAX_WINDOW);
  localparam int LEN_W   = 11;
  localparam int HCNT_W  = 11;
  localparam int SUM_W   = HCNT_W + 1;
  localparam int TWICE_W = BIN_W + 1;
  localparam int ACNT_W  = 32;
  localparam int OUT_W   = 48;

  typedef struct packed {
    logic accept;
    logic prep;
    logic scan_start;
    logic judge;
    logic dec_rd;
    logic dec_wr;
    logic inc_rd;
    logic inc_wr;
    logic out_load;
  } sma_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic out_busy;
  } sma_status_t;

endpackage
`default_nettype wire

// File: hdl/sma_ram.sv
`default_nettype none
module sma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/sma_datapath.sv
`default_nettype none
module sma_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [sma_pkg::LEN_W-1:0]   cfg_wdata,
  input  wire logic [sma_pkg::VAL_W-1:0]   in_value,
  input  wire sma_pkg::sma_cmd_t           cmd,
  output      sma_pkg::sma_status_t        status,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [sma_pkg::OUT_W-1:0]   out_data,
  output      logic                        out_full
);

  localparam logic [sma_pkg::LEN_W-1:0] MaxLen = sma_pkg::LEN_W'(sma_pkg::MAX_WINDOW);
  localparam logic [sma_pkg::BIN_W:0]   LastBin = (sma_pkg::BIN_W+1)'(sma_pkg::VALUE_BINS - 1);

  logic [sma_pkg::LEN_W-1:0]   window_length;
  logic [sma_pkg::LEN_W-1:0]   len_eff;
  logic [sma_pkg::PTR_W-1:0]   wp;
  logic [sma_pkg::LEN_W-1:0]   fill;
  logic [sma_pkg::ACNT_W-1:0]  alerts;
  logic [sma_pkg::VAL_W-1:0]   value;
  logic [sma_pkg::PTR_W-1:0]   wp_wrap;
  logic [sma_pkg::LEN_W-1:0]   wp_inc;
  logic [sma_pkg::LEN_W-1:0]   rank_lo;
  logic [sma_pkg::LEN_W-1:0]   rank_hi;

  logic [sma_pkg::VALUE_BINS-1:0] hist_vld;
  logic                         hvq;
  logic                         h_we;
  logic [sma_pkg::BIN_W-1:0]    h_waddr;
  logic [sma_pkg::HCNT_W-1:0]   h_wdata;
  logic [sma_pkg::BIN_W-1:0]    h_raddr;
  logic [sma_pkg::HCNT_W-1:0]   h_rdata;
  logic [sma_pkg::HCNT_W-1:0]   h_cnt;
  logic [sma_pkg::BIN_W-1:0]    w_rdata;

  logic [sma_pkg::BIN_W:0]      scan_addr;
  logic                         scan_run;
  logic                         tag_vld;
  logic                         tag_last;
  logic [sma_pkg::BIN_W-1:0]    tag_bin;
  logic [sma_pkg::SUM_W-1:0]    sum;
  logic [sma_pkg::SUM_W-1:0]    sum_next;
  logic                         found_lo;
  logic                         found_hi;
  logic [sma_pkg::BIN_W-1:0]    bin_lo;
  logic [sma_pkg::BIN_W-1:0]    bin_hi;
  logic                         scan_done;
  logic [sma_pkg::TWICE_W-1:0]  twice_calc;

  logic                         full_q;
  logic                         alert_q;
  logic [sma_pkg::TWICE_W-1:0]  twice_q;

  always_comb begin
    priority if (window_length == '0) begin
      len_eff = sma_pkg::LEN_W'(1);
    end else if (window_length > MaxLen) begin
      len_eff = MaxLen;
    end else begin
      len_eff = window_length;
    end
  end

  assign wp_wrap  = ({1'b0, wp} >= len_eff) ? '0 : wp;
  assign wp_inc   = {1'b0, wp} + sma_pkg::LEN_W'(1);
  assign rank_lo  = len_eff >> 1;
  assign rank_hi  = (len_eff >> 1) + sma_pkg::LEN_W'(1);
  assign h_cnt    = hvq ? h_rdata : '0;
  assign sum_next = sum + {1'b0, h_cnt};
  assign twice_calc = len_eff[0] ? {bin_hi, 1'b0} : ({1'b0, bin_lo} + {1'b0, bin_hi});

  always_comb begin
    priority if (cmd.dec_rd) begin
      h_raddr = w_rdata;
    end else if (cmd.inc_rd) begin
      h_raddr = value;
    end else begin
      h_raddr = scan_addr[sma_pkg::BIN_W-1:0];
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = value;
    h_wdata = h_cnt + sma_pkg::HCNT_W'(1);
    if (cmd.dec_wr) begin
      h_we    = (h_cnt != '0);
      h_waddr = w_rdata;
      h_wdata = h_cnt - sma_pkg::HCNT_W'(1);
    end else if (cmd.inc_wr) begin
      h_we    = 1'b1;
    end
  end

  sma_ram #(
    .WIDTH (sma_pkg::HCNT_W),
    .DEPTH (sma_pkg::VALUE_BINS)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .re    (1'b1),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sma_ram #(
    .WIDTH (sma_pkg::VAL_W),
    .DEPTH (sma_pkg::MAX_WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (cmd.inc_wr),
    .waddr (wp),
    .wdata (value),
    .re    (cmd.prep),
    .raddr (wp_wrap),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= sma_pkg::LEN_W'(1);
      wp            <= '0;
      fill          <= '0;
      alerts        <= '0;
      hist_vld      <= '0;
      scan_run      <= 1'b0;
      tag_vld       <= 1'b0;
      tag_last      <= 1'b0;
      scan_done     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      hvq <= hist_vld[h_raddr];
      if (cfg_we) begin
        window_length <= cfg_wdata;
        wp            <= '0;
        fill          <= '0;
        hist_vld      <= '0;
      end else begin
        if (h_we) begin
          hist_vld[h_waddr] <= 1'b1;
        end
        if (cmd.prep) begin
          wp <= wp_wrap;
        end
        if (cmd.inc_wr) begin
          wp <= (wp_inc >= len_eff) ? '0 : wp_inc[sma_pkg::PTR_W-1:0];
          if (!full_q) begin
            fill <= fill + sma_pkg::LEN_W'(1);
          end
        end
      end

      // Scan: issue one bin address a cycle, fold its count in the cycle after.
      if (cmd.scan_start) begin
        scan_addr <= '0;
        scan_run  <= 1'b1;
        sum       <= '0;
        found_lo  <= 1'b0;
        found_hi  <= 1'b0;
        bin_lo    <= LastBin[sma_pkg::BIN_W-1:0];
        bin_hi    <= LastBin[sma_pkg::BIN_W-1:0];
      end else if (scan_run) begin
        scan_addr <= scan_addr + (sma_pkg::BIN_W+1)'(1);
        if (scan_addr == LastBin) begin
          scan_run <= 1'b0;
        end
      end
      tag_vld   <= scan_run && !cmd.scan_start;
      tag_last  <= scan_run && (scan_addr == LastBin);
      tag_bin   <= scan_addr[sma_pkg::BIN_W-1:0];
      scan_done <= tag_vld && tag_last;
      if (tag_vld) begin
        sum <= sum_next;
        if (!found_lo && sum_next >= {1'b0, rank_lo}) begin
          found_lo <= 1'b1;
          bin_lo   <= tag_bin;
        end
        if (!found_hi && sum_next >= {1'b0, rank_hi}) begin
          found_hi <= 1'b1;
          bin_hi   <= tag_bin;
        end
      end

      if (cmd.accept) begin
        value <= in_value;
      end
      if (cmd.prep) begin
        full_q  <= (fill >= len_eff);
        alert_q <= 1'b0;
        twice_q <= '0;
      end
      if (cmd.judge) begin
        twice_q <= twice_calc;
        if ({1'b0, value} >= twice_calc) begin
          alert_q <= 1'b1;
          if (alerts != '1) begin
            alerts <= alerts + sma_pkg::ACNT_W'(1);
          end
        end
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_data  <= {(sma_pkg::OUT_W - sma_pkg::ACNT_W - sma_pkg::TWICE_W - 1)'(0),
                      alerts, twice_q, alert_q};
        out_full  <= full_q;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.full      = (fill >= len_eff);
  assign status.scan_done = scan_done;
  assign status.out_busy  = out_valid && !out_ready;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= len_eff)
    else $error("fill count exceeds window length");
  a_wp_bound: assert property (@(posedge clk) disable iff (rst) {1'b0, wp} < len_eff)
    else $error("write pointer beyond window");
  a_alerts_mono: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> alerts >= $past(alerts))
    else $error("alert counter went backward");

endmodule
`default_nettype wire

// File: hdl/sma_ctrl.sv
`default_nettype none
module sma_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire sma_pkg::sma_status_t status,
  output      sma_pkg::sma_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_DEC_RD,
    S_DEC_WR,
    S_INC_RD,
    S_INC_WR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (status.full) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_INC_RD;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_DEC_RD;
        end
      end
      S_DEC_RD: begin
        cmd.judge  = 1'b1;
        cmd.dec_rd = 1'b1;
        state_next = S_DEC_WR;
      end
      S_DEC_WR: begin
        cmd.dec_wr = 1'b1;
        state_next = S_INC_RD;
      end
      S_INC_RD: begin
        cmd.inc_rd = 1'b1;
        state_next = S_INC_WR;
      end
      S_INC_WR: begin
        cmd.inc_wr = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
      status.scan_done |-> state == S_SCAN)
    else $error("scan finished outside scan state");
  a_accept_prep: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE && in_valid) |=> state == S_PREP)
    else $error("accepted request not prepared");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
      (state == S_DONE && !status.out_busy) |=> state == S_IDLE)
    else $error("result not released");

endmodule
`default_nettype wire

// File: hdl/sliding_median_alert.sv
`default_nettype none
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[7:0] expense_value
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata alert,twice_median,alert_count;
//                                               tuser window_full
// cfg       in   cfg_we (no wait)               cfg_wdata[10:0] window_length
//
// Sequence: a request with a full window runs the scan over all 256 histogram bins
// through the single read port of the histogram RAM before its result is released;
// a request before the window is full skips the scan. A new request is taken only
// after the previous result has been loaded into the output register.
// Reset: rst is synchronous; histogram entries read as zero through per-bin valid bits.
// Stalls: a finished result waits in the output register while the next request is taken.
module sliding_median_alert (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // configuration: window_length
  input  wire logic                      cfg_we,
  input  wire logic [sma_pkg::LEN_W-1:0] cfg_wdata,
  // input stream
  input  wire logic                      s_axis_tvalid,
  output      logic                      s_axis_tready,
  input  wire logic [7:0]                s_axis_tdata,  // [7:0] expense_value
  // result stream
  output      logic                      m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output      logic [47:0]               m_axis_tdata,  // [0] alert, [9:1] twice_median,
                                                        // [41:10] alert_count, rest zero
  output      logic                      m_axis_tuser   // [0] window_full
);

  sma_pkg::sma_cmd_t    cmd;
  sma_pkg::sma_status_t status;

  // Sequence each request: prepare, scan and drop old value (full window only), add new value, release.
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the histogram, delay line, pointers and the output register.
  sma_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_value  (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_full  (m_axis_tuser)
  );

endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;

  // One result per request, unpacked from m_axis_tdata/m_axis_tuser.
  typedef struct packed {
    logic        full;
    logic        alert;
    logic [8:0]  twice;
    logic [31:0] count;
  } alert_result_t;

  // Directed stimulus: either a window length write or one request,
  // optionally with its result typed in by hand.
  typedef struct {
    bit                        set_len;
    logic [sma_pkg::LEN_W-1:0] operand;
    bit                        pinned;
    alert_result_t             want;
  } step_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [sma_pkg::LEN_W-1:0] cfg_wdata = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [47:0]               m_axis_tdata;
  logic                      m_axis_tuser;

  sliding_median_alert dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Median predictor: histogram of the trailing window plus a delay line of the
  // values in it, so the oldest value can be taken back out of its bin.
  // ---------------------------------------------------------------------------
  logic [sma_pkg::LEN_W-1:0] window_setting = sma_pkg::LEN_W'(1);
  int unsigned               bin_count [sma_pkg::VALUE_BINS];
  logic [7:0]                held_values [sma_pkg::MAX_WINDOW];
  int unsigned               slot = 0;
  int unsigned               filled = 0;
  logic [31:0]               alert_tally = '0;

  // A length write restarts the window; the alert tally survives it.
  function automatic void restart_window(input logic [sma_pkg::LEN_W-1:0] len);
    window_setting = len;
    foreach (bin_count[b]) bin_count[b] = 0;
    slot = 0;
    filled = 0;
  endfunction

  // Smallest bin whose running count reaches the given 1-based rank.
  function automatic int unsigned rank_bin(input int unsigned rank);
    int unsigned acc;
    acc = 0;
    for (int b = 0; b < sma_pkg::VALUE_BINS; b++) begin
      acc += bin_count[sma_pkg::BIN_W'(b)];
      if (acc >= rank) return b;
    end
    return sma_pkg::VALUE_BINS - 1;
  endfunction

  function automatic alert_result_t judge_value(input logic [7:0] v);
    alert_result_t r;
    int unsigned   len;
    int unsigned   old;
    r = '0;
    // A length of zero acts as one; anything past the delay line clamps to it.
    len = 32'(window_setting);
    if (len == 0) len = 1;
    if (len > sma_pkg::MAX_WINDOW) len = sma_pkg::MAX_WINDOW;
    if (slot >= len) slot = 0;
    if (filled >= len) begin
      r.full = 1'b1;
      // Even window: sum of the two middle ranks; odd: double the middle one.
      if (len % 2 == 0) r.twice = 9'(rank_bin(len / 2) + rank_bin(len / 2 + 1));
      else r.twice = 9'(2 * rank_bin(len / 2 + 1));
      if (v >= r.twice) begin
        r.alert = 1'b1;
        if (alert_tally != '1) alert_tally++;
      end
      // Drop the oldest value from its bin.
      old = 32'(held_values[sma_pkg::PTR_W'(slot)]);
      if (bin_count[sma_pkg::BIN_W'(old)] > 0) bin_count[sma_pkg::BIN_W'(old)]--;
    end else begin
      filled++;
    end
    held_values[sma_pkg::PTR_W'(slot)] = v;
    bin_count[v]++;
    slot++;
    if (slot >= len) slot = 0;
    r.count = alert_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard
  // ---------------------------------------------------------------------------
  alert_result_t pending_results[$];
  alert_result_t pinned_result = '0;
  bit            pinned_valid = 1'b0;
  int            error_count = 0;
  bit            no_idle = 1'b0;
  int            hold_off_cycles = 0;

  // Append one expected result behind the ones already waiting.
  function automatic void expect_result(input alert_result_t r);
    pending_results = {pending_results, r};
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    error_count++;
    // Keep the log bounded if the block goes badly wrong.
    if (error_count <= 100)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  // Sample everything at the rising edge: length writes update the predictor,
  // accepted requests queue their result, accepted results pop the oldest one.
  always @(posedge clk) begin : monitor
    alert_result_t got;
    alert_result_t want;
    alert_result_t predicted;
    if (rst) begin
      restart_window(sma_pkg::LEN_W'(1));
      alert_tally = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) restart_window(cfg_wdata);
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = judge_value(s_axis_tdata);
        // Hand-typed rows take precedence; the predictor still advances.
        if (pinned_valid) begin
          expect_result(pinned_result);
          pinned_valid = 1'b0;
        end else begin
          expect_result(predicted);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[0], m_axis_tdata[9:1], m_axis_tdata[41:10]};
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, alert_count", got.count, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.full !== want.full) report_mismatch("window_full", got.full, want.full);
          if (got.alert !== want.alert) report_mismatch("alert", got.alert, want.alert);
          if (got.twice !== want.twice) report_mismatch("twice_median", got.twice, want.twice);
          if (got.count !== want.count) report_mismatch("alert_count", got.count, want.count);
          if (m_axis_tdata[47:42] !== '0) report_mismatch("tdata pad", m_axis_tdata[47:42], 0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: everything changes at the falling edge.
  // ---------------------------------------------------------------------------
  task automatic offer_value(input logic [7:0] v, input bit pin, input alert_result_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_result = want;
    pinned_valid  = pin;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Write the window length only with the block drained.
  task automatic set_window(input logic [sma_pkg::LEN_W-1:0] len);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
    cfg_wdata <= len;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small values so the median stays low and spikes trip alerts;
  // some full-range values and both extremes.
  function automatic logic [7:0] draw_value();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, 40));
      6, 7:             return 8'($urandom_range(0, 255));
      8:                return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default:          return 8'($urandom_range(80, 255));
    endcase
  endfunction

  task automatic run_phase(input int unsigned len, input int n);
    set_window(sma_pkg::LEN_W'(len));
    repeat (n) offer_value(draw_value(), 1'b0, '0);
  endtask

  // Receiver: random stalls per result, plus one long hold-off on request.
  initial begin : result_sink
    int gap;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_cycles > 0) begin
        gap = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 7);
      end
      @(negedge clk);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  step_row_t directed_rows[$];

  function automatic void add_row(input step_row_t row);
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_window(input int unsigned len);
    add_row('{1'b1, sma_pkg::LEN_W'(len), 1'b0, '0});
  endfunction

  function automatic void add_value(input logic [7:0] v);
    add_row('{1'b0, sma_pkg::LEN_W'(v), 1'b0, '0});
  endfunction

  function automatic void add_pinned(input logic [7:0] v, input logic full, input logic alert,
                                     input logic [8:0] twice, input logic [31:0] count);
    alert_result_t r;
    r = '{full, alert, twice, count};
    add_row('{1'b0, sma_pkg::LEN_W'(v), 1'b1, r});
  endfunction

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Window of one out of reset: the reference is twice the previous value.
    add_pinned(8'd0,   1'b0, 1'b0, 9'd0,   32'd0);  // window still filling
    add_pinned(8'd0,   1'b1, 1'b1, 9'd0,   32'd1);  // zero median always alerts
    add_pinned(8'd255, 1'b1, 1'b1, 9'd0,   32'd2);
    add_pinned(8'd255, 1'b1, 1'b0, 9'd510, 32'd2);  // largest reference
    add_pinned(8'd0,   1'b1, 1'b0, 9'd510, 32'd2);
    add_pinned(8'd128, 1'b1, 1'b1, 9'd0,   32'd3);
    add_pinned(8'd64,  1'b1, 1'b0, 9'd256, 32'd3);
    add_pinned(8'd200, 1'b1, 1'b1, 9'd128, 32'd4);
    add_pinned(8'd100, 1'b1, 1'b0, 9'd400, 32'd4);
    add_pinned(8'd200, 1'b1, 1'b1, 9'd200, 32'd5);  // equal to the reference
    // Length zero acts as one; restart keeps the alert count.
    add_window(0);
    add_pinned(8'd7,   1'b0, 1'b0, 9'd0,   32'd5);
    add_pinned(8'd14,  1'b1, 1'b1, 9'd14,  32'd6);
    add_pinned(8'd13,  1'b1, 1'b0, 9'd28,  32'd6);
    // Even window: sum of the two middle values.
    add_window(2);
    add_pinned(8'd10,  1'b0, 1'b0, 9'd0,   32'd6);
    add_pinned(8'd30,  1'b0, 1'b0, 9'd0,   32'd6);
    add_value(8'd20);
    add_value(8'd5);
    add_value(8'd255);
    // Odd window.
    add_window(3);
    add_value(8'd1);
    add_value(8'd2);
    add_value(8'd3);
    add_value(8'd4);
    add_value(8'd9);
    add_value(8'd255);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_len) set_window(directed_rows[i].operand);
      else offer_value(directed_rows[i].operand[7:0], directed_rows[i].pinned,
                       directed_rows[i].want);
    end

    // Length extremes: all ones clamps to the delay line, then the largest
    // legal length; both stay in the filling phase.
    run_phase(32'h7FF, 30);
    run_phase(sma_pkg::MAX_WINDOW, 30);

    // Random phases over small windows.
    run_phase(2, 60);
    no_idle = 1'b1;
    run_phase(3, 60);
    no_idle = 1'b0;
    run_phase(5, 60);
    run_phase(16, 60);
    run_phase(1, 60);
    run_phase($urandom_range(6, 64), 60);

    // Hold off the receiver for a long stretch while requests keep coming,
    // so the output register fills and the input stalls.
    run_phase(8, 35);
    hold_off_cycles = 1200;
    repeat (40) offer_value(draw_value(), 1'b0, '0);

    no_idle = 1'b1;
    run_phase(31, 40);
    no_idle = 1'b0;
    repeat (35) offer_value(draw_value(), 1'b0, '0);

    // Drain, then let the block settle past one full scan.
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
